/* rtl/lmm4_pkg.sv */
// shared types and constants of the four-neighbour local maximum map
`default_nettype none

package lmm4_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IMG_W_W   = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // one line memory word: previous row and the row before it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] above;
    logic signed [SAMPLE_W-1:0] above_two;
  } line_word_t;

  // work handed to the compare stage
  typedef struct packed {
    logic                       emit;
    logic                       check;
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] down;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic                       last;
  } item_t;

endpackage

`default_nettype wire

/* rtl/lmm4_line_mem.sv */
// line memory: one write port, one registered read port
`default_nettype none

module lmm4_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire lmm4_pkg::line_word_t wdata_i,
  input  wire logic                re_i,
  input  wire logic [AW-1:0]       raddr_i,
  output      lmm4_pkg::line_word_t rdata_o
);

  lmm4_pkg::line_word_t mem [DEPTH];
  lmm4_pkg::line_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/lmm4_out_stage.sv */
// compare stage and output register
`default_nettype none

module lmm4_out_stage (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire lmm4_pkg::item_t                 item_i,
  input  wire logic signed [lmm4_pkg::SAMPLE_W-1:0] right_i,
  output      logic                            hold_o,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            is_peak_o,
  output      logic [lmm4_pkg::ROW_W-1:0]      row_o,
  output      logic [lmm4_pkg::COL_W-1:0]      col_o,
  output      logic                            last_o
);

  lmm4_pkg::item_t s1_q;
  logic s1_valid_q, s1_valid_d;
  logic s1_adv;
  logic peak;
  logic out_valid_q, out_valid_d;
  logic is_peak_q;
  logic [lmm4_pkg::ROW_W-1:0] row_q;
  logic [lmm4_pkg::COL_W-1:0] col_q;
  logic last_q;

  // right neighbour comes from the line memory's registered read, issued together with the load
  assign peak = s1_q.check &&
                ($signed(s1_q.centre) >= $signed(s1_q.up)) &&
                ($signed(s1_q.centre) >= $signed(s1_q.down)) &&
                ($signed(s1_q.centre) >= $signed(s1_q.left)) &&
                ($signed(s1_q.centre) >= $signed(right_i));

  assign s1_adv = s1_valid_q && (!s1_q.emit || !out_valid_q || !out_stall_i);
  assign hold_o = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_q.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= item_i;
    end
    if (s1_adv && s1_q.emit) begin
      is_peak_q <= peak;
      row_q     <= s1_q.row;
      col_q     <= s1_q.col;
      last_q    <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_peak_o   = is_peak_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* rtl/local_max_map_4_neighbour.sv */
// four-neighbour local maximum map over a raster-order frame
// a result passes through the compare stage register, then the output register
// throughput: one transaction per cycle while the input is not stalled; line memory read ahead by one column
// a stall on the result side reaches the input only when the compare stage is full
// reset clears counters, flush flag and handshake state; no memory clearing pass
// line memory contents are undefined until written within a frame
`default_nettype none

module local_max_map_4_neighbour #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire logic [lmm4_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lmm4_pkg::CFG_W-1:0]         cfg_data_i,
  // input channel
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic                               command_i,
  input  wire logic signed [lmm4_pkg::SAMPLE_W-1:0] sample_i,
  // result channel
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic                               is_peak_o,
  output      logic [lmm4_pkg::ROW_W-1:0]         row_o,
  output      logic [lmm4_pkg::COL_W-1:0]         col_o,
  output      logic                               last_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int VW = (WW > lmm4_pkg::IMG_W_W) ? WW : lmm4_pkg::IMG_W_W;
  // width reset value of five, clamped to the buffer depth
  localparam int RST_WM1 = (MAX_WIDTH < 5) ? (MAX_WIDTH - 1) : 4;

  // effective width and height, kept as last index
  logic [AW-1:0]              wm1_q, wm1_d;
  logic [lmm4_pkg::ROW_W-1:0] hm1_q, hm1_d;
  // frame position
  logic [AW-1:0]              col_q, col_d;
  logic [lmm4_pkg::ROW_W-1:0] row_q, row_d;
  logic                       flushing_q, flushing_d;
  // centre of the previous column
  logic signed [lmm4_pkg::SAMPLE_W-1:0] left_q;

  logic                       accept;
  logic                       hold;
  logic                       is_pixel;
  logic [AW-1:0]              c_eff;
  logic [lmm4_pkg::ROW_W-1:0] r_eff;
  logic                       at_last_col;
  logic [AW+lmm4_pkg::COL_W-1:0] col_ext;
  logic [VW-1:0]              width_val;
  logic [lmm4_pkg::ROW_W-1:0] height_val;

  lmm4_pkg::line_word_t rdata;
  lmm4_pkg::line_word_t wdata;
  logic [AW-1:0]        raddr;
  lmm4_pkg::item_t      item;

  assign accept   = in_valid_i && !hold;
  assign is_pixel = (command_i == lmm4_pkg::CMD_PIXEL);

  // a pixel during the flush restarts the frame at the top-left corner
  assign c_eff       = (flushing_q && is_pixel) ? '0 : col_q;
  assign r_eff       = (flushing_q && is_pixel) ? '0 : row_q;
  assign at_last_col = (c_eff == wm1_q);
  assign col_ext     = (AW + lmm4_pkg::COL_W)'(c_eff);

  // rdata holds the words of the current column, fetched by the previous pixel;
  // this pixel fetches the next column, which also serves as its right neighbour
  assign raddr = at_last_col ? '0 : (c_eff + AW'(1));

  always_comb begin
    wdata.above     = sample_i;
    wdata.above_two = rdata.above;
  end

  // item for the compare stage
  always_comb begin
    item.centre = rdata.above;
    item.up     = rdata.above_two;
    item.left   = left_q;
    item.down   = sample_i;
    item.col    = col_ext[lmm4_pkg::COL_W-1:0];
    if (is_pixel) begin
      item.emit  = (r_eff != '0);
      item.check = (r_eff >= lmm4_pkg::ROW_W'(2)) && (c_eff != '0) && !at_last_col;
      item.row   = r_eff - lmm4_pkg::ROW_W'(1);
      item.last  = 1'b0;
    end else begin
      // bottom row is all zero; flush outside the flush phase passes silently
      item.emit  = flushing_q;
      item.check = 1'b0;
      item.row   = hm1_q;
      item.last  = at_last_col;
    end
  end

  // clamp written width and height into their meaningful ranges
  always_comb begin
    width_val  = VW'(cfg_data_i[lmm4_pkg::IMG_W_W-1:0]);
    height_val = cfg_data_i[lmm4_pkg::ROW_W-1:0];
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (width_val < VW'(3)) begin
      wm1_d = AW'(2);
    end else if (width_val > VW'(MAX_WIDTH)) begin
      wm1_d = AW'(MAX_WIDTH - 1);
    end else begin
      wm1_d = AW'(width_val - VW'(1));
    end
    if (height_val < lmm4_pkg::ROW_W'(3)) begin
      hm1_d = lmm4_pkg::ROW_W'(2);
    end else begin
      hm1_d = height_val - lmm4_pkg::ROW_W'(1);
    end
  end

  // frame position update
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    flushing_d = flushing_q;
    if (cfg_we_i && (cfg_index_i == lmm4_pkg::REG_IMAGE_WIDTH ||
                     cfg_index_i == lmm4_pkg::REG_IMAGE_HEIGHT)) begin
      col_d      = '0;
      row_d      = '0;
      flushing_d = 1'b0;
    end else if (accept && is_pixel) begin
      flushing_d = 1'b0;
      if (at_last_col) begin
        col_d = '0;
        if (r_eff == hm1_q) begin
          row_d      = hm1_q + lmm4_pkg::ROW_W'(1);
          flushing_d = 1'b1;
        end else begin
          row_d = r_eff + lmm4_pkg::ROW_W'(1);
        end
      end else begin
        col_d = c_eff + AW'(1);
        row_d = r_eff;
      end
    end else if (accept && flushing_q) begin
      if (at_last_col) begin
        col_d      = '0;
        row_d      = '0;
        flushing_d = 1'b0;
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q      <= AW'(RST_WM1);
      hm1_q      <= lmm4_pkg::ROW_W'(4);
      col_q      <= '0;
      row_q      <= '0;
      flushing_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == lmm4_pkg::REG_IMAGE_WIDTH) begin
        wm1_q <= wm1_d;
      end
      if (cfg_we_i && cfg_index_i == lmm4_pkg::REG_IMAGE_HEIGHT) begin
        hm1_q <= hm1_d;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      flushing_q <= flushing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_pixel) begin
      left_q <= rdata.above;
    end
  end

  // line memory: write this column, prefetch the next one
  lmm4_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (accept && is_pixel),
    .waddr_i (c_eff),
    .wdata_i (wdata),
    .re_i    (accept && is_pixel),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lmm4_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .item_i      (item),
    .right_i     (rdata.above),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_peak_o   (is_peak_o),
    .row_o       (row_o),
    .col_o       (col_o),
    .last_o      (last_o)
  );

  assign in_stall_o = hold;

  // the input is only held back by a blocked result
  a_stall_only_on_blocked_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result side is free");

  // column counter never runs past the last column
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wm1_q)
    else $error("column counter beyond frame width");

  // the flush phase only follows the last row of a frame
  a_flush_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (row_q == hm1_q + lmm4_pkg::ROW_W'(1)))
    else $error("flush phase with wrong row count");

  // the frame-end flag marks a bottom-row flag, never a peak
  a_last_not_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !is_peak_o)
    else $error("last flag carries a peak");

endmodule

`default_nettype wire

/* sim/peak_flag_check_pkg.sv */
// expected flag tracking for the four-neighbour local maximum map testbench
`timescale 1ns / 100ps

package peak_flag_check_pkg;

  import lmm4_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic             is_peak;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } peak_flag_t;

  class peak_flag_tracker;
    logic [IMG_W_W-1:0]         width_reg;
    logic [ROW_W-1:0]           height_reg;
    logic signed [SAMPLE_W-1:0] prev_row [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] prev_row_two [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] left_centre;
    int unsigned                row_at;
    int unsigned                col_at;
    bit                         in_flush;
    peak_flag_t                 pending_flags[$];
    int unsigned                errors;
    int unsigned                reported;

    function new();
      width_reg   = 5;
      height_reg  = 5;
      left_centre = '0;
      row_at      = 0;
      col_at      = 0;
      in_flush    = 1'b0;
      errors      = 0;
      reported    = 0;
      foreach (prev_row[i]) begin
        prev_row[i]     = '0;
        prev_row_two[i] = '0;
      end
    endfunction

    function int unsigned frame_width();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned frame_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function int unsigned pending();
      return pending_flags.size();
    endfunction

    // a register write restarts the frame, line contents stay
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[IMG_W_W-1:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = value[ROW_W-1:0];
      else return;
      row_at   = 0;
      col_at   = 0;
      in_flush = 1'b0;
    endfunction

    function void queue_flag(bit peak, int unsigned r, int unsigned c, bit last);
      peak_flag_t f;
      f.is_peak = peak;
      f.row     = r[ROW_W-1:0];
      f.col     = c[COL_W-1:0];
      f.last    = last;
      pending_flags.push_back(f);
    endfunction

    // one accepted transaction on the input side
    function void take_item(logic cmd, logic signed [SAMPLE_W-1:0] smp);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic signed [SAMPLE_W-1:0] centre;
      bit peak;
      w = frame_width();
      h = frame_height();
      if (cmd == CMD_FLUSH) begin
        if (in_flush) begin
          c = col_at;
          queue_flag(1'b0, h - 1, c, c + 1 >= w);
          if (c + 1 >= w) begin
            in_flush = 1'b0;
            row_at   = 0;
            col_at   = 0;
          end else begin
            col_at = c + 1;
          end
        end
        return;
      end
      // a pixel abandons a flush in progress and opens a new frame
      if (in_flush) begin
        in_flush = 1'b0;
        row_at   = 0;
        col_at   = 0;
      end
      c = (col_at >= w) ? w - 1 : col_at;
      r = row_at;
      centre = prev_row[c];
      if (r >= 1) begin
        peak = 1'b0;
        if (r >= 2 && c >= 1 && c + 2 <= w)
          peak = centre >= prev_row_two[c] && centre >= smp &&
                 centre >= left_centre && centre >= prev_row[c + 1];
        queue_flag(peak, r - 1, c, 1'b0);
      end
      left_centre     = centre;
      prev_row_two[c] = centre;
      prev_row[c]     = smp;
      if (c + 1 >= w) begin
        col_at = 0;
        if (r + 1 >= h) begin
          row_at   = h;
          in_flush = 1'b1;
        end else begin
          row_at = r + 1;
        end
      end else begin
        col_at = c + 1;
      end
    endfunction

    // one accepted transaction on the result side
    function void check_flag(logic is_peak, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic last);
      peak_flag_t want;
      if (pending_flags.size() == 0) begin
        errors++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("unexpected flag: peak %0d row %0d col %0d last %0d",
                   is_peak, row, col, last);
        end
        return;
      end
      want = pending_flags.pop_front();
      if (is_peak !== want.is_peak || row !== want.row || col !== want.col ||
          last !== want.last) begin
        errors++;
        if (reported < REPORT_MAX) begin
          reported++;
          $display("flag mismatch: expected peak %0d row %0d col %0d last %0d, got peak %0d row %0d col %0d last %0d",
                   want.is_peak, want.row, want.col, want.last, is_peak, row, col, last);
        end
      end
    endfunction
  endclass

endpackage

/* sim/tb_local_max_map_4_neighbour.sv */
// testbench top for the four-neighbour local maximum map
`timescale 1ns / 100ps

module tb_local_max_map_4_neighbour;

  import lmm4_pkg::*;
  import peak_flag_check_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1550;
  localparam int unsigned DRAIN_CYCLES   = 4;    // result passes the compare and output registers after its transaction
  localparam int unsigned HOLD_CYCLES    = 400;  // long result-side hold-off
  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no transaction at all

  typedef enum int unsigned {STYLE_WIDE, STYLE_NARROW, STYLE_EXTREME, STYLE_MIXED} sample_style_t;
  typedef enum int unsigned {FRAME_FULL, FRAME_DROPPED, FRAME_CUT} frame_mode_t;
  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // 5x5 frame for the default geometry: extremes, ties at inner positions
  localparam logic signed [SAMPLE_W-1:0] CORNER_FRAME [25] = '{
    16'sh0000, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh0005,
    16'sh8000, 16'sh7fff, 16'sh0064, 16'sh7fff, 16'sh0000,
    16'sh0007, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0001,
    16'sh0000, 16'shffff, 16'sh7fff, 16'sh0003, 16'sh0002,
    16'sh0001, 16'sh0002, 16'sh0003, 16'sh0004, 16'sh0005
  };

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]           cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       command   = CMD_PIXEL;
  logic signed [SAMPLE_W-1:0] sample    = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic                       is_peak_o;
  logic [ROW_W-1:0]           row_o;
  logic [COL_W-1:0]           col_o;
  logic                       last_o;

  peak_flag_tracker flags = new();

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;  // raised by the sender side, taken by the result side
  bit          hold_on     = 1'b0;  // while set, the sender keeps offering without gaps

  local_max_map_4_neighbour dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .command_i   (command),
    .sample_i    (sample),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .is_peak_o   (is_peak_o),
    .row_o       (row_o),
    .col_o       (col_o),
    .last_o      (last_o)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // sample values: full range, a narrow band around zero for ties, or the extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_style_t style);
    int v;
    sample_style_t s;
    s = style;
    if (s == STYLE_MIXED) s = sample_style_t'($urandom_range(0, 2));
    case (s)
      STYLE_NARROW: begin
        v = $urandom_range(0, 4);
        return SAMPLE_W'(v - 2);
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // one input transaction, then burst/gap pacing of the sender
  task automatic send_item(input logic cmd, input logic signed [SAMPLE_W-1:0] value);
    in_valid <= 1'b1;
    command  <= cmd;
    sample   <= value;
    // payload holds until the first rising edge without stall
    do @(posedge clk); while (in_stall_o !== 1'b0);
    flags.take_item(cmd, value);
    items_sent++;
    @(negedge clk);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      // some bursts run straight into the next one
      if (!hold_on && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // drop valid and let every pending flag come out, plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    while (flags.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    flags.set_reg(idx, value);
  endtask

  // raster frame at the current geometry; full with flush, flush cut short, or pixels cut short
  task automatic send_frame(input sample_style_t style, input frame_mode_t mode,
                            input int unsigned cut_at);
    int unsigned w;
    int unsigned total;
    int unsigned stop_at;
    int unsigned flush_count;
    int unsigned i;
    w       = flags.frame_width();
    total   = w * flags.frame_height();
    stop_at = (mode == FRAME_CUT) ? cut_at : total;
    for (i = 0; i < stop_at; i++) begin
      // stray flush inside the frame changes nothing once a pixel has ended any open flush
      if ($urandom_range(0, 49) == 0) send_item(CMD_FLUSH, pick_sample(STYLE_WIDE));
      send_item(CMD_PIXEL, pick_sample(style));
    end
    if (mode == FRAME_CUT) return;
    flush_count = (mode == FRAME_DROPPED) ? $urandom_range(1, w - 1) : w;
    for (i = 0; i < flush_count; i++) send_item(CMD_FLUSH, pick_sample(STYLE_WIDE));
    // flush ticks past the bottom row are ignored
    if (mode == FRAME_FULL && $urandom_range(0, 9) == 0)
      send_item(CMD_FLUSH, pick_sample(STYLE_WIDE));
  endtask

  // result side: stall pattern of its own, with the long hold-off on request
  initial begin : result_side
    stall_mode_t stall_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned period;
    int unsigned cyc;
    bit          stall_next;
    stall_mode = STALL_NONE;
    mode_left  = 0;
    hold_left  = 0;
    period     = 2;
    cyc        = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_on   = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) hold_on = 1'b0;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(32, 256);
          period     = $urandom_range(2, 7);
        end
        mode_left--;
        case (stall_mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
          default:     stall_next = ((cyc % period) == 0);
        endcase
      end
      out_stall <= stall_next;
    end
  end

  // every result transaction is checked against the oldest expected flag
  always @(posedge clk) begin
    if (rst_n && out_valid_o === 1'b1 && out_stall == 1'b0)
      flags.check_flag(is_peak_o, row_o, col_o, last_o);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("local_max_map_4_neighbour verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned   phase;
    int unsigned   n_frames;
    int unsigned   f;
    int unsigned   i;
    frame_mode_t   mode;
    sample_style_t style;
    phase = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default 5x5 geometry: flush before any frame gives nothing
    send_item(CMD_FLUSH, 16'sh1234);
    for (i = 0; i < 25; i++) send_item(CMD_PIXEL, CORNER_FRAME[i]);
    // part of the bottom row, then a pixel that drops the flush and opens a frame
    send_item(CMD_FLUSH, 16'sh0000);
    send_item(CMD_FLUSH, 16'shffff);
    send_item(CMD_PIXEL, 16'sh7fff);

    // width beyond the line memory acts as full width; tallest height, cut short
    settle();
    write_reg(REG_IMAGE_WIDTH, 16'd2047);
    write_reg(REG_IMAGE_HEIGHT, 16'd65535);
    send_frame(STYLE_NARROW, FRAME_CUT, 1030);

    // random phases of small frames
    while (items_sent < ITEM_TARGET) begin
      settle();
      phase++;
      if (phase == 1) begin
        // both registers under the minimum
        write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 2)));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 2)));
      end else begin
        case ($urandom_range(0, 5))
          0: write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 2)));
          1: write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 2)));
          2: write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(3, 10)));
          default: begin
            write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(3, 9)));
            write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 7)));
          end
        endcase
      end
      n_frames = $urandom_range(1, 3);
      for (f = 0; f < n_frames; f++) begin
        // now and then the result side holds off while frames keep coming
        if (f == 0 && phase % 6 == 2) hold_req = 1'b1;
        style = sample_style_t'($urandom_range(0, 3));
        if (f == n_frames - 1 && $urandom_range(0, 4) == 0) mode = FRAME_CUT;
        else if ($urandom_range(0, 4) == 0) mode = FRAME_DROPPED;
        else mode = FRAME_FULL;
        send_frame(style, mode,
                   $urandom_range(1, flags.frame_width() * flags.frame_height() - 1));
      end
    end

    settle();
    if (flags.errors == 0 && flags.pending() == 0)
      $display("local_max_map_4_neighbour verification clean");
    else
      $display("local_max_map_4_neighbour verification failed");
    $finish;
  end

endmodule

/* files.f */
rtl/lmm4_pkg.sv
rtl/lmm4_line_mem.sv
rtl/lmm4_out_stage.sv
rtl/local_max_map_4_neighbour.sv
sim/peak_flag_check_pkg.sv
sim/tb_local_max_map_4_neighbour.sv
